// ----- sv/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Types, codes and constants shared by the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int DefaultWidth = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [30:0] res_den;
      status_type  status;
   } rsp_type;

   // Datapath command steps, issued at most one per controller state.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_GCD_INIT,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_GCD_NEXT,
      CMD_RED_INIT,
      CMD_RED_STORE,
      CMD_MUL_A,
      CMD_MUL_B,
      CMD_COMBINE,
      CMD_FINISH
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_GCD_INIT,
      S_GCD_TEST,
      S_DIV_INIT,
      S_DIV_STEP,
      S_GCD_NEXT,
      S_RED_INIT,
      S_RED_NUM,
      S_RED_NUM_STEP,
      S_RED_DEN,
      S_RED_DEN_STEP,
      S_RED_STORE,
      S_MUL_A,
      S_MUL_B,
      S_COMBINE,
      S_FINISH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic gcd_zero;
      logic skip;
      logic div_done;
      logic first_frac;
      logic last_frac;
   } stat_type;

   typedef struct packed {
      cmd_type cmd;
      logic    div_sel;   // 0: remainder for gcd, 1: quotient for reduction
      logic    red_den;   // reduction divides the denominator
   } ctl_type;

endpackage

// ----- sv/rfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer for the rational fraction ALU: canonical reduction of both
// inputs, the operation and final reduction, all on one shared datapath.
// ----------------------------------------------------------------------------
module rfa_ctrl
   import rfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:         if (req_valid) state_in = S_LOAD;
         S_LOAD:         state_in = stat.skip ? S_FINISH : S_GCD_INIT;
         S_GCD_INIT:     state_in = S_GCD_TEST;
         S_GCD_TEST:     state_in = stat.gcd_zero ? S_RED_INIT : S_DIV_INIT;
         S_DIV_INIT:     state_in = S_DIV_STEP;
         S_DIV_STEP:     if (stat.div_done) state_in = S_GCD_NEXT;
         S_GCD_NEXT:     state_in = S_GCD_TEST;
         S_RED_INIT:     state_in = S_RED_NUM;
         S_RED_NUM:      state_in = S_RED_NUM_STEP;
         S_RED_NUM_STEP: if (stat.div_done) state_in = S_RED_DEN;
         S_RED_DEN:      state_in = S_RED_DEN_STEP;
         S_RED_DEN_STEP: if (stat.div_done) state_in = S_RED_STORE;
         S_RED_STORE: begin
            if (stat.last_frac)       state_in = S_FINISH;
            else if (stat.skip)       state_in = S_FINISH;
            else if (stat.first_frac) state_in = S_GCD_INIT;
            else                      state_in = S_MUL_A;
         end
         S_MUL_A:        state_in = S_MUL_B;
         S_MUL_B:        state_in = S_COMBINE;
         S_COMBINE:      state_in = S_GCD_INIT;
         S_FINISH:       state_in = S_OUT;
         S_OUT:          if (!rsp_stall) state_in = S_IDLE;
         default:        state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '{cmd: CMD_NONE, div_sel: 1'b0, red_den: 1'b0};
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) ctl.cmd = CMD_LOAD;
         end
         S_GCD_INIT:     ctl.cmd = CMD_GCD_INIT;
         S_DIV_INIT:     ctl.cmd = CMD_DIV_INIT;
         S_DIV_STEP:     ctl.cmd = CMD_DIV_STEP;
         S_GCD_NEXT:     ctl.cmd = CMD_GCD_NEXT;
         S_RED_INIT:     ctl.cmd = CMD_RED_INIT;
         S_RED_NUM:      ctl = '{cmd: CMD_DIV_INIT, div_sel: 1'b1, red_den: 1'b0};
         S_RED_NUM_STEP: ctl = '{cmd: CMD_DIV_STEP, div_sel: 1'b1, red_den: 1'b0};
         S_RED_DEN:      ctl = '{cmd: CMD_DIV_INIT, div_sel: 1'b1, red_den: 1'b1};
         S_RED_DEN_STEP: ctl = '{cmd: CMD_DIV_STEP, div_sel: 1'b1, red_den: 1'b1};
         S_RED_STORE:    ctl.cmd = CMD_RED_STORE;
         S_MUL_A:        ctl.cmd = CMD_MUL_A;
         S_MUL_B:        ctl.cmd = CMD_MUL_B;
         S_COMBINE:      ctl.cmd = CMD_COMBINE;
         S_FINISH:       ctl.cmd = CMD_FINISH;
         S_OUT:          rsp_valid = 1'b1;
         default:        ctl.cmd = CMD_NONE;
      endcase
   end

endmodule

// ----- sv/rfa_dp.sv -----
// ----------------------------------------------------------------------------
// rfa_dp
// Datapath: sign/magnitude operands, one shared restoring divider used for
// Euclid remainders and for reduction quotients, and one multiplier.
// ----------------------------------------------------------------------------
module rfa_dp
   import rfa_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
)(
   input  logic     clock,
   input  req_type  req,
   input  ctl_type  ctl,
   output stat_type stat,
   output rsp_type  rsp
);

   localparam int MW = 2 * WIDTH;
   localparam int CW = $clog2(MW + 1);

   typedef logic [MW-1:0] mag_type;

   function automatic logic [WIDTH:0] smag(input logic [31:0] raw);
      logic [WIDTH-1:0] v;
      logic [WIDTH:0]   m;
      v = raw[WIDTH-1:0];
      m = {1'b0, v};
      if (v[WIDTH-1]) m = {1'b0, ~v} + 1'b1;
      return m;
   endfunction

   // Operand and fraction registers.
   opcode_type op_ff;
   logic    bn_neg_ff, bd_neg_ff;
   logic [WIDTH:0] bn_ff, bd_ff;
   logic    a_neg_ff, b_neg_ff;
   mag_type a_mag_ff, a_den_ff, b_mag_ff, b_den_ff;
   // Working fraction under reduction.
   logic    w_neg_ff;
   mag_type w_mag_ff, w_den_ff;
   logic [1:0] phase_ff;   // 0: a, 1: b, 2: result
   status_type st_ff;
   // Euclid registers.
   mag_type gx_ff, gy_ff;
   // Divider.
   mag_type dq_ff, dr_ff, dd_ff;
   logic [CW-1:0] dcnt_ff;
   // Products.
   mag_type p_ff, q_ff;
   rsp_type rsp_ff;

   logic zero_den;
   assign zero_den = (smag(req.a_den) == '0) || (smag(req.b_den) == '0);

   logic [MW:0] trial;
   assign trial = {dr_ff, dq_ff[MW-1]} - {1'b0, dd_ff};

   mag_type mul_x, mul_y, mul_r;
   assign mul_r = mul_x[WIDTH-1:0] * mul_y[WIDTH-1:0];

   always_comb begin
      mul_x = a_mag_ff;
      mul_y = b_den_ff;
      case (ctl.cmd)
         CMD_MUL_A: begin
            mul_x = a_mag_ff;
            mul_y = (op_ff == OP_MUL) ? b_mag_ff : b_den_ff;
         end
         CMD_MUL_B: begin
            mul_x = (op_ff == OP_MUL || op_ff == OP_DIV) ? a_den_ff : b_mag_ff;
            mul_y = (op_ff == OP_DIV) ? b_mag_ff :
                    (op_ff == OP_MUL) ? b_den_ff : a_den_ff;
         end
         default: begin
            mul_x = a_den_ff;
            mul_y = b_den_ff;
         end
      endcase
   end

   localparam logic [MW-1:0] Limit = MW'(1) << (WIDTH - 1);

   logic sub_neg;
   assign sub_neg = (op_ff == OP_SUB) ? !b_neg_ff : b_neg_ff;

   logic [63:0] res_num_wide;
   assign res_num_wide = w_neg_ff ? (64'd0 - 64'(w_mag_ff)) : 64'(w_mag_ff);

   always_ff @(posedge clock) begin
      case (ctl.cmd)
         CMD_LOAD: begin
            op_ff  <= req.opcode;
            bn_ff  <= smag(req.b_num);
            bd_ff  <= smag(req.b_den);
            bn_neg_ff <= req.b_num[WIDTH-1];
            bd_neg_ff <= req.b_den[WIDTH-1];
            w_neg_ff <= req.a_num[WIDTH-1] ^ req.a_den[WIDTH-1];
            w_mag_ff <= MW'(smag(req.a_num));
            w_den_ff <= MW'(smag(req.a_den));
            phase_ff <= 2'd0;
            st_ff    <= zero_den ? ST_ZERO_DEN : ST_OK;
         end
         CMD_GCD_INIT: begin
            gx_ff <= w_mag_ff;
            gy_ff <= w_den_ff;
         end
         CMD_DIV_INIT: begin
            dq_ff <= ctl.div_sel ? (ctl.red_den ? w_den_ff : w_mag_ff) : gx_ff;
            dd_ff <= ctl.div_sel ? gx_ff : gy_ff;
            dr_ff <= '0;
            dcnt_ff <= '0;
         end
         CMD_DIV_STEP: begin
            if (!trial[MW]) begin
               dr_ff <= trial[MW-1:0];
               dq_ff <= {dq_ff[MW-2:0], 1'b1};
            end else begin
               dr_ff <= {dr_ff[MW-2:0], dq_ff[MW-1]};
               dq_ff <= {dq_ff[MW-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 1'b1;
            if (ctl.div_sel && dcnt_ff == CW'(MW - 1)) begin
               if (ctl.red_den) w_den_ff <= trial[MW] ? {dq_ff[MW-2:0], 1'b0}
                                                       : {dq_ff[MW-2:0], 1'b1};
               else             w_mag_ff <= trial[MW] ? {dq_ff[MW-2:0], 1'b0}
                                                       : {dq_ff[MW-2:0], 1'b1};
            end
         end
         CMD_GCD_NEXT: begin
            gx_ff <= gy_ff;
            gy_ff <= dr_ff;
         end
         CMD_RED_INIT: begin
            if (w_mag_ff == '0 || w_den_ff == '0) begin
               w_neg_ff <= 1'b0;
               w_mag_ff <= '0;
               w_den_ff <= MW'(1);
               gx_ff    <= MW'(1);
            end
         end
         CMD_RED_STORE: begin
            phase_ff <= phase_ff + 2'd1;
            if (phase_ff == 2'd0) begin
               a_neg_ff <= w_neg_ff;
               a_mag_ff <= w_mag_ff;
               a_den_ff <= w_den_ff;
               w_neg_ff <= bn_neg_ff ^ bd_neg_ff;
               w_mag_ff <= MW'(bn_ff);
               w_den_ff <= MW'(bd_ff);
            end else if (phase_ff == 2'd1) begin
               b_neg_ff <= w_neg_ff;
               b_mag_ff <= w_mag_ff;
               b_den_ff <= w_den_ff;
               if (op_ff == OP_DIV && w_mag_ff == '0) st_ff <= ST_DIV_ZERO;
            end
         end
         CMD_MUL_A: p_ff <= mul_r;
         CMD_MUL_B: q_ff <= mul_r;
         CMD_COMBINE: begin
            w_den_ff <= (op_ff == OP_DIV || op_ff == OP_MUL) ? q_ff : mul_r;
            if (op_ff == OP_MUL || op_ff == OP_DIV) begin
               w_neg_ff <= a_neg_ff ^ b_neg_ff;
               w_mag_ff <= p_ff;
            end else if (a_neg_ff == sub_neg) begin
               w_neg_ff <= a_neg_ff;
               w_mag_ff <= p_ff + q_ff;
            end else if (p_ff >= q_ff) begin
               w_neg_ff <= a_neg_ff;
               w_mag_ff <= p_ff - q_ff;
            end else begin
               w_neg_ff <= sub_neg;
               w_mag_ff <= q_ff - p_ff;
            end
         end
         CMD_FINISH: begin
            if (st_ff != ST_OK) begin
               rsp_ff <= '{res_num: '0, res_den: '0, status: st_ff};
            end else if (w_den_ff > Limit - MW'(1) ||
                         (w_neg_ff ? (w_mag_ff > Limit)
                                   : (w_mag_ff > Limit - MW'(1)))) begin
               rsp_ff <= '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
            end else begin
               rsp_ff <= '{res_num: res_num_wide[31:0], res_den: 31'(w_den_ff),
                           status: ST_OK};
            end
         end
         default: ;
      endcase
   end

   assign stat.gcd_zero   = (gy_ff == '0);
   assign stat.div_done   = (dcnt_ff == CW'(MW - 1));
   assign stat.first_frac = (phase_ff == 2'd0);
   assign stat.last_frac  = (phase_ff == 2'd2);
   // Division by a zero fraction is seen while b is being stored.
   assign stat.skip       = (st_ff != ST_OK) ||
                            (ctl.cmd == CMD_RED_STORE && phase_ff == 2'd1 &&
                             op_ff == OP_DIV && w_mag_ff == '0);
   assign rsp = rsp_ff;

endmodule

// ----- sv/rational_fraction_alu_top.sv -----
// The shared divider produces one quotient bit per cycle.
// Throughput: one item at a time; next item accepted the cycle after the result is taken.
// A zero denominator input skips straight to the result. Reset: synchronous,
// active high, returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_fraction_alu_top
// Add, subtract, multiply or divide two signed fractions, result reduced.
// ----------------------------------------------------------------------------
module rational_fraction_alu_top
   import rfa_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   stat_type stat;
   ctl_type  ctl;

   rfa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .ctl
   );

   rfa_dp #(.WIDTH(WIDTH)) u_dp (
      .clock, .req(req_data), .ctl, .stat, .rsp(rsp_data)
   );

endmodule
